// ===== hw/rtl/bsp_pkg.sv =====
`timescale 1ns / 1ps
package bsp_pkg;

  localparam int BUFFER_BYTES = 4096;
  localparam int STORE_BYTES  = BUFFER_BYTES + 4;
  localparam int STORE_WORDS  = (STORE_BYTES + 3) / 4;
  localparam int BANK_WORDS   = (STORE_WORDS + 1) / 2;
  localparam int BANK_AW      = $clog2(BANK_WORDS);
  localparam int IDX_W        = 13;
  localparam int LEN_W        = 13;
  localparam int SWEEP_BYTES  = BANK_WORDS * 8;

  typedef enum logic [3:0] {
    FN_WRITE     = 4'd0,
    FN_WRITE_S   = 4'd1,
    FN_WRITE_BIT = 4'd2,
    FN_READ      = 4'd3,
    FN_READ_S    = 4'd4,
    FN_PEEK      = 4'd5,
    FN_SKIP      = 4'd6,
    FN_ALIGN     = 4'd7,
    FN_REWIND    = 4'd8,
    FN_CLEAR     = 4'd9
  } func_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EX,
    ST_WAIT,
    ST_CLR
  } state_e;

  typedef struct packed {
    logic       bit_mode;
    logic       bit_set;
    logic [5:0] nbits;
    logic [1:0] shift;
    logic [2:0] offset;
  } win_ctrl_t;

  function automatic logic [31:0] low_mask(input logic [5:0] n);
    logic [32:0] m;
    m = (33'd1 << n) - 33'd1;
    return (n >= 6'd32) ? 32'hFFFF_FFFF : m[31:0];
  endfunction

endpackage

// ===== hw/rtl/bsp_in_if.sv =====
`timescale 1ns / 1ps
interface bsp_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  func;
  logic [31:0] value;
  logic [5:0]  nbits;

  modport source (output valid, output func, output value, output nbits, input ready);
  modport sink (input valid, input func, input value, input nbits, output ready);
endinterface

// ===== hw/rtl/bsp_out_if.sv =====
`timescale 1ns / 1ps
interface bsp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_value;
  logic        overflow;
  logic [15:0] bit_position;

  modport source (output valid, output read_value, output overflow, output bit_position,
                  input ready);
  modport sink (input valid, input read_value, input overflow, input bit_position,
                output ready);
endinterface

// ===== hw/rtl/lsb_first_bit_packer_unpacker.sv =====
`timescale 1ns / 1ps
// Field, bit, skip, align and rewind ops pass through ST_EX into the output register.
// Signed reads do two read passes and signed writes two read-modify-write passes, via ST_WAIT.
// A clear zeroes eight bytes a cycle up to the cursor plus four, within the set length.
// A new beat is taken only in ST_IDLE, once the last result is in the output register.
// After reset a sweep zeroes the whole store before the first beat is taken.
module lsb_first_bit_packer_unpacker import bsp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_wdata_i,
  bsp_in_if.sink           in_i,
  bsp_out_if.source        out_o
);

  state_e           state_q, state_d;
  logic             phase_q, phase_d;
  logic [3:0]       func_q;
  logic [31:0]      value_q;
  logic [5:0]       n_q;
  logic [31:0]      data_q, data_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [2:0]       off_q, off_d;
  logic             ovf_q, ovf_d;
  logic [LEN_W-1:0] used_q;
  logic [BANK_AW-1:0] cnt_q, cnt_d;
  logic [LEN_W-1:0] size_q, size_d;
  logic             ov_q;
  logic [31:0]      ord_q;
  logic             oovf_q;
  logic [15:0]      opos_q;

  logic [LEN_W-1:0] limit;
  logic [10:0]      wa;
  logic [BANK_AW-1:0] ev_addr, od_addr;
  logic [31:0]      ev_rd, od_rd, ev_wd, od_wd;
  logic [3:0]       ev_be, od_be;
  logic             mem_we, clr_mode, fin, go, clr_last, over_start, fw_over;
  logic [31:0]      lo, hi, new_lo, new_hi, field, rd_val, res, pass_data;
  logic [5:0]       sn_m1, pass_n, p;
  logic [IDX_W-1:0] adv_idx;
  win_ctrl_t        wctrl;
  logic signed [32:0] vs, maxv, sat;
  logic             neg;
  logic [31:0]      mag;
  logic [13:0]      csize, sweep_base;
  logic [5:0]       nb_sat;

  assign limit   = (used_q > LEN_W'(BUFFER_BYTES)) ? LEN_W'(BUFFER_BYTES) : used_q;
  assign wa      = idx_q[12:2];
  assign od_addr = clr_mode ? cnt_q : wa[10:1];
  assign ev_addr = clr_mode ? cnt_q : (wa[0] ? wa[10:1] + BANK_AW'(1) : wa[10:1]);
  assign lo      = wa[0] ? od_rd : ev_rd;
  assign hi      = wa[0] ? ev_rd : od_rd;
  assign go      = !ov_q || out_o.ready;
  assign nb_sat  = (in_i.nbits > 6'd32) ? 6'd32 : in_i.nbits;

  always_comb begin
    sn_m1 = (n_q == 6'd0) ? 6'd0 : n_q - 6'd1;
    vs    = {value_q[31], value_q};
    maxv  = {1'b0, low_mask(sn_m1)};
    sat   = vs;
    if (vs > maxv) begin
      sat = maxv;
    end
    if (vs < -maxv) begin
      sat = -maxv;
    end
    neg = sat[32];
    mag = neg ? 32'(-sat) : sat[31:0];
  end

  always_comb begin
    if (func_q == FN_READ_S) begin
      pass_n = phase_q ? sn_m1 : 6'd1;
    end else if (func_q == FN_WRITE_S) begin
      pass_n = phase_q ? sn_m1 : 6'd1;
    end else if (func_q == FN_WRITE_BIT) begin
      pass_n = 6'd1;
    end else begin
      pass_n = n_q;
    end
    pass_data       = (func_q == FN_WRITE) ? value_q : data_q;
    wctrl.bit_mode  = (func_q == FN_WRITE_BIT) || ((func_q == FN_WRITE_S) && !phase_q);
    wctrl.bit_set   = (func_q == FN_WRITE_S) ? neg : (value_q != 32'd0);
    wctrl.nbits     = pass_n;
    wctrl.shift     = idx_q[1:0];
    wctrl.offset    = off_q;
    over_start      = idx_q >= limit;
    fw_over         = ({1'b0, idx_q} + {11'd0, pass_n[5:3]}) > {1'b0, limit};
    p               = {3'b000, off_q} + pass_n;
    adv_idx         = idx_q + IDX_W'(p[5:3]);
    rd_val          = over_start ? 32'hFFFF_FFFF : field;
    csize           = {1'b0, idx_q} + 14'(off_q != 3'd0) + 14'd4;
    sweep_base      = {1'b0, cnt_q, 3'b000};
    clr_last        = (sweep_base + 14'd8) >= {1'b0, size_q};
  end

  bsp_window u_window (
    .lo_i    (lo),
    .hi_i    (hi),
    .ctrl_i  (wctrl),
    .data_i  (pass_data),
    .field_o (field),
    .lo_o    (new_lo),
    .hi_o    (new_hi)
  );

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    data_d   = data_q;
    idx_d    = idx_q;
    off_d    = off_q;
    ovf_d    = ovf_q;
    cnt_d    = cnt_q;
    size_d   = size_q;
    mem_we   = 1'b0;
    clr_mode = 1'b0;
    fin      = 1'b0;
    res      = 32'd0;
    case (state_q)
      ST_INIT: begin
        clr_mode = 1'b1;
        mem_we   = 1'b1;
        cnt_d    = cnt_q + BANK_AW'(1);
        if (clr_last) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = ST_EX;
          phase_d = 1'b0;
        end
      end
      ST_WAIT: begin
        state_d = ST_EX;
      end
      ST_CLR: begin
        clr_mode = 1'b1;
        if (clr_last) begin
          fin = 1'b1;
          if (go) begin
            mem_we  = 1'b1;
            cnt_d   = '0;
            idx_d   = '0;
            off_d   = '0;
            ovf_d   = 1'b0;
            state_d = ST_IDLE;
          end
        end else begin
          mem_we = 1'b1;
          cnt_d  = cnt_q + BANK_AW'(1);
        end
      end
      ST_EX: begin
        case (func_e'(func_q))
          FN_WRITE_S, FN_WRITE: begin
            if ((func_q == FN_WRITE_S) && !phase_q) begin
              data_d  = mag;
              phase_d = 1'b1;
              state_d = ST_WAIT;
              if (over_start) begin
                ovf_d = 1'b1;
              end else begin
                mem_we = 1'b1;
                idx_d  = adv_idx;
                off_d  = p[2:0];
              end
            end else begin
              fin = 1'b1;
              if (go) begin
                state_d = ST_IDLE;
                if (!ovf_q) begin
                  if (fw_over) begin
                    ovf_d = 1'b1;
                  end else begin
                    mem_we = 1'b1;
                    idx_d  = adv_idx;
                    off_d  = p[2:0];
                  end
                end
              end
            end
          end
          FN_WRITE_BIT: begin
            fin = 1'b1;
            if (go) begin
              state_d = ST_IDLE;
              if (over_start) begin
                ovf_d = 1'b1;
              end else begin
                mem_we = 1'b1;
                idx_d  = adv_idx;
                off_d  = p[2:0];
              end
            end
          end
          FN_READ_S, FN_READ, FN_SKIP: begin
            if ((func_q == FN_READ_S) && !phase_q) begin
              data_d  = rd_val;
              phase_d = 1'b1;
              state_d = ST_WAIT;
            end else begin
              fin = 1'b1;
              if (func_q == FN_READ_S) begin
                res = (data_q != 32'd0) ? 32'd0 - rd_val : rd_val;
              end else if (func_q == FN_READ) begin
                res = rd_val;
              end
              if (go) begin
                state_d = ST_IDLE;
              end
            end
            if (go || ((func_q == FN_READ_S) && !phase_q)) begin
              if (over_start) begin
                ovf_d = 1'b1;
              end else begin
                idx_d = adv_idx;
                off_d = p[2:0];
              end
            end
          end
          FN_PEEK: begin
            fin = 1'b1;
            res = rd_val;
            if (go) begin
              state_d = ST_IDLE;
              if (over_start) begin
                ovf_d = 1'b1;
              end
            end
          end
          FN_ALIGN: begin
            fin = 1'b1;
            if (go) begin
              state_d = ST_IDLE;
              if (off_q != 3'd0) begin
                idx_d = idx_q + IDX_W'(1);
                off_d = '0;
              end
            end
          end
          FN_REWIND: begin
            fin = 1'b1;
            if (go) begin
              state_d = ST_IDLE;
              idx_d   = '0;
              off_d   = '0;
              ovf_d   = 1'b0;
            end
          end
          FN_CLEAR: begin
            size_d  = (csize > {1'b0, limit}) ? limit : csize[LEN_W-1:0];
            cnt_d   = '0;
            state_d = ST_CLR;
          end
          default: begin
            fin = 1'b1;
            if (go) begin
              state_d = ST_IDLE;
            end
          end
        endcase
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (clr_mode) begin
        ev_be[k] = (sweep_base + 14'(k)) < {1'b0, size_q};
        od_be[k] = (sweep_base + 14'(k + 4)) < {1'b0, size_q};
      end else begin
        ev_be[k] = 1'b1;
        od_be[k] = 1'b1;
      end
    end
    if (clr_mode) begin
      ev_wd = 32'd0;
      od_wd = 32'd0;
    end else begin
      ev_wd = wa[0] ? new_hi : new_lo;
      od_wd = wa[0] ? new_lo : new_hi;
    end
  end

  bsp_bank u_bank_even (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .be_i    (ev_be),
    .addr_i  (ev_addr),
    .wdata_i (ev_wd),
    .rdata_o (ev_rd)
  );

  bsp_bank u_bank_odd (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .be_i    (od_be),
    .addr_i  (od_addr),
    .wdata_i (od_wd),
    .rdata_o (od_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      phase_q <= 1'b0;
      idx_q   <= '0;
      off_q   <= '0;
      ovf_q   <= 1'b0;
      used_q  <= LEN_W'(BUFFER_BYTES);
      cnt_q   <= '0;
      size_q  <= LEN_W'(SWEEP_BYTES);
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      idx_q   <= idx_d;
      off_q   <= off_d;
      ovf_q   <= ovf_d;
      cnt_q   <= cnt_d;
      size_q  <= size_d;
      if (cfg_we_i) begin
        used_q <= cfg_wdata_i;
      end
      if (fin && go) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    if (in_i.valid && in_i.ready) begin
      func_q  <= in_i.func;
      value_q <= in_i.value;
      n_q     <= nb_sat;
    end
    if (fin && go) begin
      ord_q  <= res;
      oovf_q <= ovf_d;
      opos_q <= {idx_d, off_d};
    end
  end

  assign in_i.ready         = (state_q == ST_IDLE);
  assign out_o.valid        = ov_q;
  assign out_o.read_value   = ord_q;
  assign out_o.overflow     = oovf_q;
  assign out_o.bit_position = opos_q;

endmodule

// ===== hw/rtl/bsp_bank.sv =====
`timescale 1ns / 1ps
module bsp_bank import bsp_pkg::*; (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [3:0]         be_i,
  input  logic [BANK_AW-1:0] addr_i,
  input  logic [31:0]        wdata_i,
  output logic [31:0]        rdata_o
);

  logic [3:0][7:0] mem [BANK_WORDS];
  logic [31:0]     rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int k = 0; k < 4; k++) begin
        if (be_i[k]) begin
          mem[addr_i][k] <= wdata_i[k*8 +: 8];
        end
      end
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/bsp_window.sv =====
`timescale 1ns / 1ps
module bsp_window import bsp_pkg::*; (
  input  logic [31:0] lo_i,
  input  logic [31:0] hi_i,
  input  win_ctrl_t   ctrl_i,
  input  logic [31:0] data_i,
  output logic [31:0] field_o,
  output logic [31:0] lo_o,
  output logic [31:0] hi_o
);

  logic [63:0] old_w;
  logic [63:0] win;
  logic [63:0] ins;
  logic [63:0] bitm;
  logic [63:0] new_w;
  logic [4:0]  pos;
  logic [31:0] mask;

  always_comb begin
    old_w   = {hi_i, lo_i};
    mask    = low_mask(ctrl_i.nbits);
    win     = old_w >> {ctrl_i.shift, 3'b000};
    field_o = win[ctrl_i.offset +: 32];
    field_o = field_o & mask;
    pos     = {ctrl_i.shift, 3'b000} + {2'b00, ctrl_i.offset};
    ins     = {32'd0, data_i & mask} << pos;
    bitm    = 64'd1 << pos;
    if (ctrl_i.bit_mode) begin
      new_w = ctrl_i.bit_set ? (old_w | bitm) : (old_w & ~bitm);
    end else begin
      new_w = old_w | ins;
    end
    lo_o = new_w[31:0];
    hi_o = new_w[63:32];
  end

endmodule

// ===== dv/bsp_checker.sv =====
`timescale 1ns / 1ps
module bsp_checker import bsp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_wdata_i,
  bsp_in_if                in_if,
  bsp_out_if               out_if,
  output int               errors_o,
  output int               pending_o
);

  typedef struct packed {
    logic [31:0] read_value;
    logic        overflow;
    logic [15:0] bit_position;
  } cursor_result_t;

  logic [7:0]     store_mem [STORE_BYTES];
  int unsigned    cur_byte;
  int unsigned    cur_bit;
  bit             ovf;
  int unsigned    used_len;
  cursor_result_t expected_q [$];
  int             errors;
  int             pending;

  assign errors_o  = errors;
  assign pending_o = pending;

  function automatic int unsigned bound_bytes();
    return (used_len < BUFFER_BYTES) ? used_len : BUFFER_BYTES;
  endfunction

  function automatic logic [31:0] width_mask(input int unsigned n);
    logic [32:0] m;
    m = (33'd1 << n) - 33'd1;
    return (n >= 32) ? 32'hFFFF_FFFF : m[31:0];
  endfunction

  function automatic void move_cursor(input int unsigned n);
    int unsigned p;
    p = cur_bit + n;
    cur_byte += p >> 3;
    cur_bit = p & 7;
  endfunction

  function automatic logic [31:0] take_field(input int unsigned n);
    logic [39:0] w;
    logic [39:0] s;
    w = '0;
    if (cur_byte >= bound_bytes()) begin
      ovf = 1'b1;
      return 32'hFFFF_FFFF;
    end
    for (int i = 0; i < 5; i++) begin
      if (cur_byte + i < STORE_BYTES) w[8*i +: 8] = store_mem[cur_byte + i];
    end
    s = w >> cur_bit;
    move_cursor(n);
    return s[31:0] & width_mask(n);
  endfunction

  function automatic void put_bit(input bit set);
    if (cur_byte >= bound_bytes()) begin
      ovf = 1'b1;
      return;
    end
    store_mem[cur_byte][cur_bit] = set;
    move_cursor(1);
  endfunction

  function automatic void put_field(input logic [31:0] data, input int unsigned n);
    logic [39:0] w;
    if (ovf) return;
    if (cur_byte + (n >> 3) > bound_bytes()) begin
      ovf = 1'b1;
      return;
    end
    w = {8'd0, data & width_mask(n)} << cur_bit;
    for (int i = 0; i < 5; i++) begin
      if (cur_byte + i < STORE_BYTES) store_mem[cur_byte + i] |= w[8*i +: 8];
    end
    move_cursor(n);
  endfunction

  function automatic cursor_result_t apply_op(input logic [3:0] fn, input logic [31:0] val,
                                              input logic [5:0] nb);
    int unsigned    n;
    int unsigned    sn;
    int unsigned    save_byte;
    int unsigned    save_bit;
    int unsigned    clr;
    longint         v;
    longint         maxv;
    bit             neg;
    logic [31:0]    sgn;
    logic [31:0]    mag;
    logic [31:0]    rv;
    logic [31:0]    pos;
    cursor_result_t r;
    n = (nb > 32) ? 32 : nb;
    sn = (n == 0) ? 1 : n;
    rv = '0;
    case (fn)
      FN_WRITE: put_field(val, n);
      FN_WRITE_S: begin
        v = longint'(signed'(val));
        maxv = longint'(width_mask(sn - 1));
        if (v > maxv) v = maxv;
        if (v < -maxv) v = -maxv;
        neg = v < 0;
        put_bit(neg);
        put_field(neg ? 32'(-v) : 32'(v), sn - 1);
      end
      FN_WRITE_BIT: put_bit(val != 0);
      FN_READ: rv = take_field(n);
      FN_READ_S: begin
        sgn = take_field(1);
        mag = take_field(sn - 1);
        rv = (sgn != 0) ? -mag : mag;
      end
      FN_PEEK: begin
        save_byte = cur_byte;
        save_bit = cur_bit;
        rv = take_field(n);
        cur_byte = save_byte;
        cur_bit = save_bit;
      end
      FN_SKIP: begin
        if (cur_byte >= bound_bytes()) ovf = 1'b1;
        else move_cursor(n);
      end
      FN_ALIGN: begin
        if (cur_bit != 0) begin
          cur_byte++;
          cur_bit = 0;
        end
      end
      FN_REWIND: begin
        cur_byte = 0;
        cur_bit = 0;
        ovf = 1'b0;
      end
      FN_CLEAR: begin
        clr = cur_byte + ((cur_bit != 0) ? 1 : 0) + 4;
        if (clr > bound_bytes()) clr = bound_bytes();
        for (int i = 0; i < clr; i++) store_mem[i] = 8'd0;
        cur_byte = 0;
        cur_bit = 0;
        ovf = 1'b0;
      end
      default: ;
    endcase
    pos = cur_byte * 8 + cur_bit;
    r.read_value = rv;
    r.overflow = ovf;
    r.bit_position = pos[15:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cursor_result_t got;
    cursor_result_t exp;
    if (!rst_ni) begin
      for (int i = 0; i < STORE_BYTES; i++) store_mem[i] = 8'd0;
      cur_byte = 0;
      cur_bit = 0;
      ovf = 1'b0;
      used_len = BUFFER_BYTES;
      expected_q.delete();
      errors = 0;
    end else begin
      if (cfg_we_i) used_len = cfg_wdata_i;
      if (in_if.valid && in_if.ready) begin
        expected_q.push_back(apply_op(in_if.func, in_if.value, in_if.nbits));
      end
      if (out_if.valid && out_if.ready) begin
        got.read_value = out_if.read_value;
        got.overflow = out_if.overflow;
        got.bit_position = out_if.bit_position;
        if (expected_q.size() == 0) begin
          $error("unexpected result beat");
          errors++;
        end else begin
          exp = expected_q.pop_front();
          if (got.read_value !== exp.read_value) begin
            $error("read_value expected %h actual %h", exp.read_value, got.read_value);
            errors++;
          end
          if (got.overflow !== exp.overflow) begin
            $error("overflow expected %b actual %b", exp.overflow, got.overflow);
            errors++;
          end
          if (got.bit_position !== exp.bit_position) begin
            $error("bit_position expected %0d actual %0d", exp.bit_position,
                   got.bit_position);
            errors++;
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb import bsp_pkg::*;;

  localparam int          STALL_LIMIT = 6000;
  localparam logic [3:0]  FN_BAD_LO   = 4'd10;
  localparam logic [3:0]  FN_BAD_HI   = 4'd15;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [LEN_W-1:0] cfg_wdata;
  int               send_idle;
  int               recv_idle;
  int               errors;
  int               pending;
  logic             op_taken;
  int               stall_cycles;

  bsp_in_if  in_if ();
  bsp_out_if out_if ();

  lsb_first_bit_packer_unpacker dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  bsp_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_if       (in_if),
    .out_if      (out_if),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    op_taken <= in_if.valid && in_if.ready;
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  always @(negedge clk) begin
    out_if.ready = ($urandom_range(99) >= recv_idle);
  end

  task automatic send(input logic [3:0] f, input logic [31:0] v, input logic [5:0] n);
    while ($urandom_range(99) < send_idle) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.func = f;
    in_if.value = v;
    in_if.nbits = n;
    do @(negedge clk); while (!op_taken);
  endtask

  task automatic drain();
    in_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_length(input int len);
    drain();
    cfg_we = 1'b1;
    cfg_wdata = len[LEN_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [5:0] pick_width();
    if ($urandom_range(9) == 0) return 6'($urandom_range(63, 33));
    return 6'($urandom_range(32));
  endfunction

  task automatic send_noise();
    logic [3:0] f;
    case ($urandom_range(19))
      0, 1, 2, 3: f = FN_WRITE;
      4, 5:       f = FN_WRITE_S;
      6, 7:       f = FN_WRITE_BIT;
      8, 9, 10:   f = FN_READ;
      11, 12:     f = FN_READ_S;
      13:         f = FN_PEEK;
      14:         f = FN_SKIP;
      15:         f = FN_ALIGN;
      16:         f = FN_REWIND;
      17:         f = FN_CLEAR;
      default:    f = 4'($urandom_range(FN_BAD_HI, FN_BAD_LO));
    endcase
    send(f, pick_value(), pick_width());
  endtask

  // Writes a run of fields and reads them back in the same order.
  task automatic send_round_trip(inout int count);
    logic [3:0] wf [16];
    logic [5:0] wn [16];
    int         k;
    k = $urandom_range(16, 1);
    send($urandom_range(1) ? FN_CLEAR : FN_REWIND, 32'h0, 6'd0);
    for (int i = 0; i < k; i++) begin
      case ($urandom_range(2))
        0: wf[i] = FN_WRITE;
        1: wf[i] = FN_WRITE_S;
        default: wf[i] = FN_WRITE_BIT;
      endcase
      wn[i] = pick_width();
      send(wf[i], pick_value(), wn[i]);
    end
    send(FN_REWIND, 32'h0, 6'd0);
    for (int i = 0; i < k; i++) begin
      if ($urandom_range(4) == 0) send(FN_PEEK, $urandom, wn[i]);
      case (wf[i])
        FN_WRITE:   send(FN_READ, $urandom, wn[i]);
        FN_WRITE_S: send(FN_READ_S, $urandom, wn[i]);
        default:    send(FN_READ, $urandom, 6'd1);
      endcase
    end
    count += 2 * k + 2;
  endtask

  task automatic run_random(input int items);
    int count;
    count = 0;
    while (count < items) begin
      if ($urandom_range(9) < 7) begin
        send_round_trip(count);
      end else begin
        send_noise();
        count++;
      end
    end
  endtask

  initial begin
    int lens [3][3];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.func = FN_WRITE;
    in_if.value = '0;
    in_if.nbits = '0;
    out_if.ready = 1'b0;
    send_idle = 0;
    recv_idle = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    send(FN_WRITE, 32'hFFFF_FFFF, 6'd32);
    send(FN_WRITE, 32'hFFFF_FFFF, 6'd0);
    send(FN_WRITE_S, 32'h8000_0000, 6'd32);
    send(FN_WRITE_S, 32'hFFFF_FFFB, 6'd0);
    send(FN_WRITE_S, 32'd7, 6'd3);
    send(FN_WRITE_BIT, 32'h8000_0000, 6'd0);
    send(FN_WRITE_BIT, 32'h0, 6'd0);
    send(FN_WRITE, 32'hA5A5_A5A5, 6'd63);
    send(FN_ALIGN, 32'h0, 6'd0);
    send(FN_ALIGN, 32'h0, 6'd0);
    send(FN_REWIND, 32'h0, 6'd0);
    send(FN_READ, 32'h0, 6'd32);
    send(FN_READ_S, 32'h0, 6'd32);
    send(FN_READ_S, 32'h0, 6'd0);
    send(FN_PEEK, 32'h0, 6'd17);
    send(FN_SKIP, 32'h0, 6'd63);
    send(FN_READ, 32'h0, 6'd0);
    send(FN_BAD_LO, 32'hFFFF_FFFF, 6'd63);
    send(FN_BAD_HI, 32'hFFFF_FFFF, 6'd63);
    send(FN_CLEAR, 32'h0, 6'd0);
    set_length(0);
    send(FN_WRITE_BIT, 32'd1, 6'd0);
    send(FN_READ, 32'h0, 6'd8);
    send(FN_READ_S, 32'h0, 6'd8);
    send(FN_WRITE, 32'hFFFF_FFFF, 6'd0);
    send(FN_WRITE_S, 32'h1, 6'd4);
    send(FN_CLEAR, 32'h0, 6'd0);

    lens = '{'{BUFFER_BYTES, 1, 16}, '{(1 << LEN_W) - 1, 40, 0}, '{3, 8, BUFFER_BYTES}};
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 7 : (ph == 1) ? 61 : 0;
      recv_idle = (ph == 0) ? 61 : (ph == 1) ? 7 : 0;
      for (int j = 0; j < 3; j++) begin
        set_length((ph == 2 && j == 1) ? $urandom_range(64) : lens[ph][j]);
        run_random(175);
      end
    end

    in_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/bsp_pkg.sv
hw/rtl/bsp_in_if.sv
hw/rtl/bsp_out_if.sv
hw/rtl/bsp_bank.sv
hw/rtl/bsp_window.sv
hw/rtl/lsb_first_bit_packer_unpacker.sv
dv/bsp_checker.sv
dv/tb.sv
